// ===== sv/lli_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the quotient fix-up for the line intersection pipeline.
// Depends on nothing; lli_front and line_line_intersection refer to it by scoped names.
package lli_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int Q_WIDTH       = 32;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = DIFF_W + COORD_WIDTH;
   localparam int DP_W   = 2 * DIFF_W;
   localparam int LINC_W = 2 * COORD_WIDTH + 2;
   localparam int DET_W  = 2 * COORD_WIDTH + 3;
   localparam int PX_W   = DIFF_W + LINC_W;
   localparam int NUM_W  = 3 * COORD_WIDTH + 4;

   localparam logic [Q_WIDTH-1:0] Q_MAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
   localparam logic [Q_WIDTH-1:0] Q_MIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] dx;
      logic signed [COORD_WIDTH-1:0] dy;
   } req_type;

   typedef struct packed {
      logic signed [Q_WIDTH-1:0] ix;
      logic signed [Q_WIDTH-1:0] iy;
      logic                      parallel;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic parallel;
      logic negx;
      logic negy;
      logic presatx;
      logic presaty;
   } side_type;

   typedef struct packed {
      logic [Q_WIDTH-1:0] val;
      logic               sat;
   } qres_type;

   function automatic qres_type quot_fix(logic [Q_WIDTH-1:0] q, logic neg, logic over);
      qres_type r;
      logic     big;
      big   = over || (neg ? (q > Q_MIN) : (q > Q_MAX));
      r.sat = big;
      if (big) begin
         r.val = neg ? Q_MIN : Q_MAX;
      end else begin
         r.val = neg ? (~q + Q_WIDTH'(1)) : q;
      end
      return r;
   endfunction

endpackage

// ===== sv/lli_front.sv =====
`timescale 1ns / 1ps
// Front end: line coefficients, determinant, numerators and their magnitudes, seven stages.
// Depends on lli_pkg.
module lli_front #(
   parameter int FRAC_BITS = lli_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  lli_pkg::req_type                      in_data,
   output lli_pkg::side_type                     side,
   output logic [lli_pkg::NUM_W+FRAC_BITS-1:0]   nx,
   output logic [lli_pkg::NUM_W+FRAC_BITS-1:0]   ny,
   output logic [lli_pkg::DET_W-1:0]             dm
);
   localparam int CW  = lli_pkg::COORD_WIDTH;
   localparam int DFW = lli_pkg::DIFF_W;
   localparam int PW  = lli_pkg::PROD_W;
   localparam int DPW = lli_pkg::DP_W;
   localparam int LW  = lli_pkg::LINC_W;
   localparam int DTW = lli_pkg::DET_W;
   localparam int XW  = lli_pkg::PX_W;
   localparam int NMW = lli_pkg::NUM_W;
   localparam int NW  = NMW + FRAC_BITS;
   localparam int NE  = NW + lli_pkg::Q_WIDTH;

   logic [6:0] v_ff;

   logic signed [DFW-1:0] s1_a1_ff, s1_b1_ff, s1_a2_ff, s1_b2_ff;
   logic signed [CW-1:0]  s1_ax_ff, s1_ay_ff, s1_cx_ff, s1_cy_ff;

   logic signed [PW-1:0]  s2_m1_ff, s2_m2_ff, s2_m3_ff, s2_m4_ff;
   logic signed [DPW-1:0] s2_dp1_ff, s2_dp2_ff;
   logic signed [DFW-1:0] s2_a1_ff, s2_b1_ff, s2_a2_ff, s2_b2_ff;

   logic signed [LW-1:0]  s3_c1_ff, s3_c2_ff;
   logic signed [DTW-1:0] s3_det_ff;
   logic signed [DFW-1:0] s3_a1_ff, s3_b1_ff, s3_a2_ff, s3_b2_ff;

   logic signed [XW-1:0]  s4_px1_ff, s4_px2_ff, s4_py1_ff, s4_py2_ff;
   logic [DTW-1:0]        s4_dm_ff, s5_dm_ff, s6_dm_ff, s7_dm_ff;
   logic                  s4_dneg_ff, s5_dneg_ff;
   logic                  s4_dz_ff, s5_dz_ff, s6_dz_ff, s7_dz_ff;

   logic signed [NMW-1:0] s5_numx_ff, s5_numy_ff;

   logic [NMW-1:0]        s6_nmx_ff, s6_nmy_ff;
   logic                  s6_negx_ff, s6_negy_ff, s7_negx_ff, s7_negy_ff;

   logic [NW-1:0]         s7_nx_ff, s7_ny_ff;
   logic                  s7_psx_ff, s7_psy_ff;

   logic [NW-1:0]         nx_in, ny_in;
   logic [NE-1:0]         dlim;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   assign nx_in = NW'(s6_nmx_ff) << FRAC_BITS;
   assign ny_in = NW'(s6_nmy_ff) << FRAC_BITS;
   assign dlim  = NE'(s6_dm_ff) << lli_pkg::Q_WIDTH;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a1_ff <= DFW'(in_data.by) - DFW'(in_data.ay);
         s1_b1_ff <= DFW'(in_data.ax) - DFW'(in_data.bx);
         s1_a2_ff <= DFW'(in_data.dy) - DFW'(in_data.cy);
         s1_b2_ff <= DFW'(in_data.cx) - DFW'(in_data.dx);
         s1_ax_ff <= in_data.ax;
         s1_ay_ff <= in_data.ay;
         s1_cx_ff <= in_data.cx;
         s1_cy_ff <= in_data.cy;

         s2_m1_ff  <= PW'(s1_a1_ff) * PW'(s1_ax_ff);
         s2_m2_ff  <= PW'(s1_b1_ff) * PW'(s1_ay_ff);
         s2_m3_ff  <= PW'(s1_a2_ff) * PW'(s1_cx_ff);
         s2_m4_ff  <= PW'(s1_b2_ff) * PW'(s1_cy_ff);
         s2_dp1_ff <= DPW'(s1_a1_ff) * DPW'(s1_b2_ff);
         s2_dp2_ff <= DPW'(s1_a2_ff) * DPW'(s1_b1_ff);
         s2_a1_ff  <= s1_a1_ff;
         s2_b1_ff  <= s1_b1_ff;
         s2_a2_ff  <= s1_a2_ff;
         s2_b2_ff  <= s1_b2_ff;

         s3_c1_ff  <= LW'(s2_m1_ff) + LW'(s2_m2_ff);
         s3_c2_ff  <= LW'(s2_m3_ff) + LW'(s2_m4_ff);
         s3_det_ff <= DTW'(s2_dp1_ff) - DTW'(s2_dp2_ff);
         s3_a1_ff  <= s2_a1_ff;
         s3_b1_ff  <= s2_b1_ff;
         s3_a2_ff  <= s2_a2_ff;
         s3_b2_ff  <= s2_b2_ff;

         s4_px1_ff  <= XW'(s3_b2_ff) * XW'(s3_c1_ff);
         s4_px2_ff  <= XW'(s3_b1_ff) * XW'(s3_c2_ff);
         s4_py1_ff  <= XW'(s3_a1_ff) * XW'(s3_c2_ff);
         s4_py2_ff  <= XW'(s3_a2_ff) * XW'(s3_c1_ff);
         s4_dm_ff   <= s3_det_ff[DTW-1] ? DTW'(-s3_det_ff) : DTW'(s3_det_ff);
         s4_dneg_ff <= s3_det_ff[DTW-1];
         s4_dz_ff   <= (s3_det_ff == '0);

         s5_numx_ff <= NMW'(s4_px1_ff) - NMW'(s4_px2_ff);
         s5_numy_ff <= NMW'(s4_py1_ff) - NMW'(s4_py2_ff);
         s5_dm_ff   <= s4_dm_ff;
         s5_dneg_ff <= s4_dneg_ff;
         s5_dz_ff   <= s4_dz_ff;

         s6_nmx_ff  <= s5_numx_ff[NMW-1] ? NMW'(-s5_numx_ff) : NMW'(s5_numx_ff);
         s6_nmy_ff  <= s5_numy_ff[NMW-1] ? NMW'(-s5_numy_ff) : NMW'(s5_numy_ff);
         s6_negx_ff <= s5_numx_ff[NMW-1] ^ s5_dneg_ff;
         s6_negy_ff <= s5_numy_ff[NMW-1] ^ s5_dneg_ff;
         s6_dm_ff   <= s5_dm_ff;
         s6_dz_ff   <= s5_dz_ff;

         s7_nx_ff   <= nx_in;
         s7_ny_ff   <= ny_in;
         s7_psx_ff  <= NE'(nx_in) >= dlim;
         s7_psy_ff  <= NE'(ny_in) >= dlim;
         s7_negx_ff <= s6_negx_ff;
         s7_negy_ff <= s6_negy_ff;
         s7_dm_ff   <= s6_dm_ff;
         s7_dz_ff   <= s6_dz_ff;
      end
   end

   assign side.valid    = v_ff[6];
   assign side.parallel = s7_dz_ff;
   assign side.negx     = s7_negx_ff;
   assign side.negy     = s7_negy_ff;
   assign side.presatx  = s7_psx_ff;
   assign side.presaty  = s7_psy_ff;
   assign nx            = s7_nx_ff;
   assign ny            = s7_ny_ff;
   assign dm            = s7_dm_ff;

endmodule

// ===== sv/lli_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per register stage, QB stages deep.
// Depends on nothing but its parameters.
module lli_div #(
   parameter int NW = 68,
   parameter int DW = 35,
   parameter int QB = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] n,
   input  logic [DW-1:0] d,
   output logic [QB-1:0] q
);
   localparam int NE = NW + QB;

   logic [NE-1:0] n_ext;
   logic [DW-1:0] rem_v [QB+1];
   logic [QB-1:0] nq_v  [QB+1];
   logic [DW-1:0] d_v   [QB+1];

   assign n_ext    = NE'(n);
   assign rem_v[0] = DW'(n_ext >> QB);
   assign nq_v[0]  = n_ext[QB-1:0];
   assign d_v[0]   = d;

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] rem_ff, d_ff;
      logic [QB-1:0] nq_ff;

      assign t  = {rem_v[k], nq_v[k][QB-1]};
      assign ge = t >= {1'b0, d_v[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= ge ? DW'(t - {1'b0, d_v[k]}) : DW'(t);
            nq_ff  <= {nq_v[k][QB-2:0], ge};
            d_ff   <= d_v[k];
         end
      end

      assign rem_v[k+1] = rem_ff;
      assign nq_v[k+1]  = nq_ff;
      assign d_v[k+1]   = d_ff;
   end

   assign q = nq_v[QB];

endmodule

// ===== sv/line_line_intersection.sv =====
`timescale 1ns / 1ps
// Top level of the line intersection pipeline: front end, two dividers, output register.
// Depends on lli_pkg, lli_front and lli_div.
//
//   channel | ports                          | moves
//   req     | req_valid, req_stall, req_data | four points A B C D
//   rsp     | rsp_valid, rsp_stall, rsp_data | ix, iy, parallel, saturated
//
// One transfer per cycle is taken and one result given while the output is not stalled; the path
// runs through seven front-end stages, one stage per quotient bit in the dividers (32), one output register.
// Reset clears all valid bits and the side-band pipeline; other payload registers are not reset.
// A stalled, full output register freezes every stage and raises req_stall.
module line_line_intersection #(
   parameter int FRAC_BITS = lli_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lli_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lli_pkg::rsp_type rsp_data
);
   localparam int NW = lli_pkg::NUM_W + FRAC_BITS;
   localparam int QB = lli_pkg::Q_WIDTH;
   localparam int DW = lli_pkg::DET_W;

   logic              en;
   lli_pkg::side_type side_v [QB+1];
   lli_pkg::side_type side_ff [QB];
   logic [NW-1:0]     nx, ny;
   logic [DW-1:0]     dm;
   logic [QB-1:0]     qx, qy;
   lli_pkg::qres_type rx, ry;
   lli_pkg::side_type last;
   logic              rsp_valid_ff;
   lli_pkg::rsp_type  rsp_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   lli_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .side     (side_v[0]),
      .nx       (nx),
      .ny       (ny),
      .dm       (dm)
   );

   lli_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_x (
      .clock (clock),
      .en    (en),
      .n     (nx),
      .d     (dm),
      .q     (qx)
   );

   lli_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_y (
      .clock (clock),
      .en    (en),
      .n     (ny),
      .d     (dm),
      .q     (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QB; k++) begin
            side_ff[k] <= '0;
         end
      end else if (en) begin
         for (int k = 0; k < QB; k++) begin
            side_ff[k] <= side_v[k];
         end
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_side
      assign side_v[k+1] = side_ff[k];
   end

   assign last = side_v[QB];
   assign rx   = lli_pkg::quot_fix(qx, last.negx, last.presatx);
   assign ry   = lli_pkg::quot_fix(qy, last.negy, last.presaty);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (last.parallel) begin
            rsp_ff.ix        <= lli_pkg::Q_MAX;
            rsp_ff.iy        <= lli_pkg::Q_MAX;
            rsp_ff.parallel  <= 1'b1;
            rsp_ff.saturated <= 1'b0;
         end else begin
            rsp_ff.ix        <= rx.val;
            rsp_ff.iy        <= ry.val;
            rsp_ff.parallel  <= 1'b0;
            rsp_ff.saturated <= rx.sat || ry.sat;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_parallel_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parallel |->
         !rsp_data.saturated && rsp_data.ix == lli_pkg::Q_MAX && rsp_data.iy == lli_pkg::Q_MAX)
      else $error("parallel result without maximum coordinates");

   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.ix == lli_pkg::Q_MAX || rsp_data.ix == lli_pkg::Q_MIN ||
         rsp_data.iy == lli_pkg::Q_MAX || rsp_data.iy == lli_pkg::Q_MIN)
      else $error("saturated result without a limit value");

   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(side_ff[QB-1]))
      else $error("last divider stage moved during a stall");
`endif

endmodule
